// ===== hw/rtl/wpap_pkg.sv =====
`timescale 1ns / 1ps

package wpap_pkg;

  // Default configuration
  localparam int DefCells     = 2560;
  localparam int DefChannels  = 4;
  localparam int DefPedEvents = 10;
  localparam int DefTrigRing  = 128;

  // Pedestal sum word
  localparam int SumW = 16;

  // Result queue depth
  localparam int OutDepth = 3;

  // Vernier term: (14888000 - 2222*v) / 100000, truncated toward zero.
  // Written as +/- (2222*|v - 6700| +/- 600) / 100000 so the numerator
  // stays a 27-bit magnitude.
  localparam int VernZero  = 6700;
  localparam int VernGain  = 2222;
  localparam int VernBias  = 600;
  // ceil(2^44 / 100000); exact floor division for numerators below 2^27
  localparam int VernRecip = 175921861;
  localparam int VernShift = 44;

  typedef enum logic {
    FuncHeader = 1'b0,
    FuncSample = 1'b1
  } func_e;

  typedef enum logic {
    KindHeader = 1'b0,
    KindSample = 1'b1
  } kind_e;

  // One result beat
  typedef struct packed {
    kind_e              kind;
    logic signed [12:0] rotation;
    logic [11:0]        aligned_cell;
    logic [1:0]         out_channel;
    logic signed [12:0] corrected;
    logic [11:0]        peak_value;
    logic [1:0]         peak_channel;
    logic [11:0]        peak_cell;
  } res_t;

  // Rotation unit status
  typedef struct packed {
    logic signed [12:0] rot_new;      // rotation of the header in stage 1
    logic signed [12:0] rot_cur;      // rotation in force for samples
    logic [11:0]        neg_rot_mod;  // (-rot_cur) mod cells
  } rot_t;

endpackage

// ===== hw/rtl/wpap_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
// A read and a write to the same address in one cycle return the old data.
module wpap_ram #(
  parameter int Width = wpap_pkg::SumW,
  parameter int Depth = wpap_pkg::DefCells * wpap_pkg::DefChannels
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/wpap_rot.sv =====
`timescale 1ns / 1ps

// Cell rotation unit: coarse term from the trigger record, vernier term by
// reciprocal multiply, saturated sum, and the rotation's negated residue.
module wpap_rot #(
  parameter int Cells    = wpap_pkg::DefCells,
  parameter int TrigRing = wpap_pkg::DefTrigRing
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,        // header beat accepted
  input  logic [15:0]         trigger_word_i,
  input  logic [15:0]         vernier_word_i,
  input  logic                commit_i,       // header in stage 1
  output wpap_pkg::rot_t      rot_o
);

  // Multiple of Cells at or above 4096, keeps the residue input positive
  localparam int Off      = ((4096 + Cells - 1) / Cells) * Cells;
  localparam int ModSteps = $clog2(12288 / Cells + 1);

  // Coarse table, clipped to 14 bits (final result saturates anyway)
  logic signed [13:0] coarse_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_coarse
    localparam int Raw  = (Cells * (TrigRing - g)) / TrigRing;
    localparam int Clip = (Raw > 8191) ? 8191 : ((Raw < -8192) ? -8192 : Raw);
    assign coarse_tab[g] = 14'(Clip);
  end

  // Vernier numerator from the input port
  logic        vneg;
  logic [15:0] vdist;
  logic [27:0] vprod;
  logic [26:0] vnum;

  always_comb begin
    vneg  = vernier_word_i > 16'(wpap_pkg::VernZero);
    vdist = vneg ? (vernier_word_i - 16'(wpap_pkg::VernZero))
                 : (16'(wpap_pkg::VernZero) - vernier_word_i);
    vprod = 28'(vdist) * 28'(wpap_pkg::VernGain);
    vnum  = vneg ? (27'(vprod) - 27'(wpap_pkg::VernBias))
                 : (27'(vprod) + 27'(wpap_pkg::VernBias));
  end

  logic signed [13:0] coarse_q;
  logic [26:0]        vnum_q;
  logic               vneg_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      coarse_q <= coarse_tab[trigger_word_i[7:0]];
      vnum_q   <= vnum;
      vneg_q   <= vneg;
    end
  end

  // Stage 1: divide by 100000, add coarse, saturate
  logic [54:0]        qprod;
  logic [10:0]        fine_mag;
  logic signed [11:0] fine;
  logic signed [14:0] rsum;
  logic signed [12:0] rot_new;

  always_comb begin
    qprod    = 55'(vnum_q) * 55'(wpap_pkg::VernRecip);
    fine_mag = qprod[wpap_pkg::VernShift +: 11];
    fine     = vneg_q ? -$signed({1'b0, fine_mag}) : $signed({1'b0, fine_mag});
    rsum     = 15'(coarse_q) + 15'(fine);
    if (rsum > 15'sd4095) begin
      rot_new = 13'sd4095;
    end else if (rsum < -15'sd4096) begin
      rot_new = -13'sd4096;
    end else begin
      rot_new = 13'(rsum);
    end
  end

  logic signed [12:0] rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= '0;
    end else if (commit_i) begin
      rot_q <= rot_new;
    end
  end

  // (-rot) mod Cells by conditional subtraction, registered from the committed rotation
  logic signed [15:0] sdiff;
  logic [14:0]        rem;

  always_comb begin
    sdiff = 16'(Off) - 16'(rot_q);
    rem   = 15'(sdiff);
    for (int k = ModSteps - 1; k >= 0; k--) begin
      if (rem >= 15'(Cells << k)) begin
        rem = rem - 15'(Cells << k);
      end
    end
  end

  logic [11:0] nrm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q <= '0;
    end else begin
      nrm_q <= 12'(rem);
    end
  end

  assign rot_o.rot_new     = rot_new;
  assign rot_o.rot_cur     = rot_q;
  assign rot_o.neg_rot_mod = nrm_q;

endmodule

// ===== hw/rtl/wpap_fifo.sv =====
`timescale 1ns / 1ps

// Result queue, valid/stall on the read side
module wpap_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wpap_pkg::res_t item_i,
  output logic           valid_o,
  input  logic           stall_i,
  output wpap_pkg::res_t item_o,
  output logic [1:0]     count_o
);

  wpap_pkg::res_t mem_q [wpap_pkg::OutDepth];
  logic [1:0] wr_ptr_q, rd_ptr_q, count_q;
  logic       pop;

  assign valid_o = count_q != 2'd0;
  assign pop     = valid_o && !stall_i;
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers wrap at the queue depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == 2'(wpap_pkg::OutDepth - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == 2'(wpap_pkg::OutDepth - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> count_q == $past(count_q) - 2'd1)
    else $error("queue count did not drop on a pop");
`endif

endmodule

// ===== hw/rtl/waveform_pedestal_align_peak.sv =====
`timescale 1ns / 1ps

// Pipeline: an accepted input beat is registered into stage 1 (RAM read), then
//   pushed into the result queue; out_valid_o is high while the queue holds a beat.
// Throughput: one beat per cycle while the queue has room; a header beat is followed
//   by an input bubble while the rotation residue settles. The RAM read-modify-write sets the rate.
// Reset: control clears at once, then a clearing pass zeroes all CHANNELS*CELLS
//   pedestal RAM entries (10240 by default) with in_stall_o held high.
module waveform_pedestal_align_peak #(
  parameter int CELLS           = wpap_pkg::DefCells,
  parameter int CHANNELS        = wpap_pkg::DefChannels,
  parameter int PEDESTAL_EVENTS = wpap_pkg::DefPedEvents,
  parameter int TRIGGER_RING    = wpap_pkg::DefTrigRing
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [15:0]        trigger_word_i,
  input  logic [15:0]        vernier_word_i,
  input  logic [1:0]         channel_i,
  input  logic [11:0]        cell_req_i,
  input  logic [15:0]        sample_word_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [12:0] rotation_o,
  output logic [11:0]        aligned_cell_o,
  output logic [1:0]         out_channel_o,
  output logic signed [12:0] corrected_o,
  output logic [11:0]        peak_value_o,
  output logic [1:0]         peak_channel_o,
  output logic [11:0]        peak_cell_o
);

  localparam int Depth     = CHANNELS * CELLS;
  localparam int AddrW     = $clog2(Depth);
  localparam int CellSteps = $clog2(4096 / CELLS + 1);
  // pedestal = sum / PEDESTAL_EVENTS by reciprocal multiply
  localparam int PedShift  = wpap_pkg::SumW + $clog2(PEDESTAL_EVENTS);
  localparam int PedMul    = ((1 << PedShift) + PEDESTAL_EVENTS - 1) / PEDESTAL_EVENTS;

  localparam int SumW = wpap_pkg::SumW;

  logic in_accept;
  logic in_sample;
  logic learn_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_q <= 1'b0;
    end else if (cfg_we_i) begin
      learn_q <= cfg_wdata_i;
    end
  end

  // Input: channel and cell residues, RAM address
  logic [1:0]       ch_in;
  logic [12:0]      cell_tmp;
  logic [11:0]      cell_in;
  logic [AddrW-1:0] addr_in;

  always_comb begin
    ch_in = channel_i;
    for (int k = 0; k < 3; k++) begin
      if (int'(ch_in) >= CHANNELS) begin
        ch_in = ch_in - 2'(CHANNELS);
      end
    end
    cell_tmp = 13'(cell_req_i);
    for (int k = CellSteps - 1; k >= 0; k--) begin
      if (cell_tmp >= 13'(CELLS << k)) begin
        cell_tmp = cell_tmp - 13'(CELLS << k);
      end
    end
    cell_in = 12'(cell_tmp);
    addr_in = AddrW'(ch_in) * AddrW'(CELLS) + AddrW'(cell_in);
  end

  // Stage 1 registers
  logic                  s1_v_q;
  wpap_pkg::func_e       s1_func_q;
  logic [1:0]            s1_ch_q;
  logic [11:0]           s1_cell_q;
  logic [11:0]           s1_raw_q;
  logic [AddrW-1:0]      s1_addr_q;
  logic                  s1_hdr;
  logic                  s1_smp;

  assign s1_hdr = s1_v_q && (s1_func_q == wpap_pkg::FuncHeader);
  assign s1_smp = s1_v_q && (s1_func_q == wpap_pkg::FuncSample);

  // Clearing pass
  logic             clr_q;
  logic [AddrW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Input stall: clearing, header bubble, or no room downstream
  logic [1:0] fifo_count;

  assign in_stall_o = clr_q || s1_hdr ||
                      ((3'(s1_v_q) + 3'(fifo_count)) >= 3'(wpap_pkg::OutDepth));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_sample  = func_i == wpap_pkg::FuncSample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= wpap_pkg::func_e'(func_i);
      s1_ch_q   <= ch_in;
      s1_cell_q <= cell_in;
      s1_raw_q  <= sample_word_i[11:0];
      s1_addr_q <= addr_in;
    end
  end

  // Rotation unit
  wpap_pkg::rot_t rot;

  wpap_rot #(
    .Cells    (CELLS),
    .TrigRing (TRIGGER_RING)
  ) u_rot (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (in_accept && !in_sample),
    .trigger_word_i (trigger_word_i),
    .vernier_word_i (vernier_word_i),
    .commit_i       (s1_hdr),
    .rot_o          (rot)
  );

  // Pedestal sum RAM
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [SumW-1:0]  wr_data;
  logic [SumW-1:0]  rd_data;
  logic [SumW-1:0]  new_sum;

  assign wr_en   = clr_q || (s1_smp && learn_q);
  assign wr_addr = clr_q ? clr_addr_q : s1_addr_q;
  assign wr_data = clr_q ? '0 : new_sum;

  wpap_ram #(
    .Width (SumW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (in_accept && in_sample),
    .raddr_i (addr_in),
    .rdata_o (rd_data)
  );

  // Forward the write made at the edge of this item's read
  logic             fwd_v_q;
  logic [AddrW-1:0] fwd_addr_q;
  logic [SumW-1:0]  fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else begin
      fwd_v_q <= s1_smp && learn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= new_sum;
  end

  // Stage 1 sample math
  logic [SumW-1:0]     base;
  logic [33:0]         ped_prod;
  logic [SumW-1:0]     ped;
  logic signed [17:0]  diff;
  logic signed [12:0]  corr;
  logic [12:0]         asum;
  logic [11:0]         aligned;
  logic                take_peak;

  logic [11:0] best_value_q;
  logic [1:0]  best_channel_q;
  logic [11:0] best_cell_q;

  always_comb begin
    base     = (fwd_v_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rd_data;
    ped_prod = 34'(base) * 34'(PedMul);
    ped      = SumW'(ped_prod >> PedShift);
    diff     = $signed({6'b0, s1_raw_q}) - $signed({2'b0, ped});
    corr     = (diff < -18'sd4095) ? -13'sd4095 : 13'(diff);
    new_sum  = base + SumW'(s1_raw_q);
    asum     = 13'(s1_cell_q) + 13'(rot.neg_rot_mod);
    aligned  = (asum >= 13'(CELLS)) ? 12'(asum - 13'(CELLS)) : 12'(asum);
    take_peak = !corr[12] && (corr != 13'sd0) && (corr[11:0] > best_value_q);
  end

  // Peak tracker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_value_q   <= '0;
      best_channel_q <= '0;
      best_cell_q    <= '0;
    end else if (s1_hdr) begin
      best_value_q   <= '0;
      best_channel_q <= '0;
      best_cell_q    <= '0;
    end else if (s1_smp && take_peak) begin
      best_value_q   <= corr[11:0];
      best_channel_q <= s1_ch_q;
      best_cell_q    <= aligned;
    end
  end

  // Result beat
  wpap_pkg::res_t res;

  always_comb begin
    if (s1_func_q == wpap_pkg::FuncHeader) begin
      res.kind         = wpap_pkg::KindHeader;
      res.rotation     = rot.rot_new;
      res.aligned_cell = '0;
      res.out_channel  = '0;
      res.corrected    = '0;
      res.peak_value   = '0;
      res.peak_channel = '0;
      res.peak_cell    = '0;
    end else begin
      res.kind         = wpap_pkg::KindSample;
      res.rotation     = rot.rot_cur;
      res.aligned_cell = aligned;
      res.out_channel  = s1_ch_q;
      res.corrected    = corr;
      res.peak_value   = take_peak ? corr[11:0] : best_value_q;
      res.peak_channel = take_peak ? s1_ch_q : best_channel_q;
      res.peak_cell    = take_peak ? aligned : best_cell_q;
    end
  end

  // Result queue
  wpap_pkg::res_t head;

  wpap_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_v_q),
    .item_i  (res),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (head),
    .count_o (fifo_count)
  );

  assign kind_o         = head.kind;
  assign rotation_o     = head.rotation;
  assign aligned_cell_o = head.aligned_cell;
  assign out_channel_o  = head.out_channel;
  assign corrected_o    = head.corrected;
  assign peak_value_o   = head.peak_value;
  assign peak_channel_o = head.peak_channel;
  assign peak_cell_o    = head.peak_cell;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> fifo_count < 2'(wpap_pkg::OutDepth))
    else $error("stage 1 beat with no room in result queue");

  a_hdr_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_hdr |=> !s1_smp)
    else $error("sample entered stage 1 before rotation residue settled");

  a_peak_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_smp |=> best_value_q >= $past(best_value_q))
    else $error("peak value dropped on a sample");
`endif

endmodule

// ===== tb/pedestal_peak_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the pedestal/alignment/peak block, predicts each
// result beat from the accepted input beats and compares field by field.
module pedestal_peak_checker
  import wpap_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               func_i,
  input  logic [15:0]        trigger_word_i,
  input  logic [15:0]        vernier_word_i,
  input  logic [1:0]         channel_i,
  input  logic [11:0]        cell_req_i,
  input  logic [15:0]        sample_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               kind_i,
  input  logic signed [12:0] rotation_i,
  input  logic [11:0]        aligned_cell_i,
  input  logic [1:0]         out_channel_i,
  input  logic signed [12:0] corrected_i,
  input  logic [11:0]        peak_value_i,
  input  logic [1:0]         peak_channel_i,
  input  logic [11:0]        peak_cell_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  // Vernier term constants, units of 1e-5 cell
  localparam longint FineOffset = 14888000;
  localparam longint FineGain   = 2222;
  localparam longint FineDiv    = 100000;

  // Shadow state of the block
  logic [SumW-1:0]    ped_sum [DefChannels*DefCells];
  logic signed [12:0] rot_now;
  logic [11:0]        best_val;
  logic [1:0]         best_ch;
  logic [11:0]        best_cl;
  logic               learn_on;

  res_t expected_results [$];
  int   mismatch_count = 0;

  // Coarse cell shift from the trigger record plus the vernier correction
  function automatic logic signed [12:0] rotation_from(logic [15:0] trig, logic [15:0] vern);
    longint t, v, coarse, fine, total;
    t = longint'(trig[7:0]);
    v = longint'(vern);
    coarse = (longint'(DefCells) * (longint'(DefTrigRing) - t)) / longint'(DefTrigRing);
    fine = (FineOffset - FineGain * v) / FineDiv;
    total = coarse + fine;
    if (total < -4096) total = -4096;
    if (total > 4095) total = 4095;
    return 13'(total);
  endfunction

  // Work out the result of one accepted beat and queue it
  task automatic predict_readout_beat();
    res_t r;
    int   cell_idx, addr, raw, ped, corr, k;
    r = '0;
    if (func_e'(func_i) == FuncHeader) begin
      rot_now    = rotation_from(trigger_word_i, vernier_word_i);
      best_val   = '0;
      best_ch    = '0;
      best_cl    = '0;
      r.kind     = KindHeader;
      r.rotation = rot_now;
    end else begin
      cell_idx = int'(cell_req_i) % DefCells;
      addr = (int'(channel_i) % DefChannels) * DefCells + cell_idx;
      raw  = int'(sample_word_i[11:0]);
      ped  = int'(ped_sum[addr]) / DefPedEvents;
      corr = raw - ped;
      if (corr < -4095) corr = -4095;
      if (corr > 4095) corr = 4095;
      // true modulo, rotation may be negative
      k = (cell_idx - int'(rot_now)) % DefCells;
      if (k < 0) k += DefCells;
      // sum updates after the correction used the old value
      if (learn_on) ped_sum[addr] = ped_sum[addr] + SumW'(sample_word_i[11:0]);
      // strict greater-than; ties and negatives keep the old peak
      if (corr > 0 && corr > int'(best_val)) begin
        best_val = corr[11:0];
        best_ch  = 2'(int'(channel_i) % DefChannels);
        best_cl  = k[11:0];
      end
      r.kind         = KindSample;
      r.rotation     = rot_now;
      r.aligned_cell = k[11:0];
      r.out_channel  = 2'(int'(channel_i) % DefChannels);
      r.corrected    = corr[12:0];
    end
    r.peak_value   = best_val;
    r.peak_channel = best_ch;
    r.peak_cell    = best_cl;
    expected_results.push_back(r);
  endtask

  task automatic check_field(string name, integer want_v, integer got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // Compare the beat on the output channel with the oldest expectation
  task automatic check_result_beat();
    res_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result beat, expected none, actual kind %0d", $time, kind_i);
      return;
    end
    want = expected_results.pop_front();
    check_field("kind", want.kind, kind_i);
    check_field("rotation", want.rotation, rotation_i);
    check_field("aligned_cell", want.aligned_cell, aligned_cell_i);
    check_field("out_channel", want.out_channel, out_channel_i);
    check_field("corrected", want.corrected, corrected_i);
    check_field("peak_value", want.peak_value, peak_value_i);
    check_field("peak_channel", want.peak_channel, peak_channel_i);
    check_field("peak_cell", want.peak_cell, peak_cell_i);
  endtask

  // Outputs first, so a beat can never match an expectation queued at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (ped_sum[i]) ped_sum[i] = '0;
      rot_now  = '0;
      best_val = '0;
      best_ch  = '0;
      best_cl  = '0;
      learn_on = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result_beat();
      if (in_valid_i && !in_stall_i) predict_readout_beat();
      if (cfg_we_i) learn_on = cfg_wdata_i;
    end
    fail_count_o <= mismatch_count;
    pending_o    <= expected_results.size();
  end

endmodule

// ===== tb/waveform_pedestal_align_peak_test.sv =====
`timescale 1ns / 1ps

module waveform_pedestal_align_peak_test;
  import wpap_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int PhaseItems   = 220;
  localparam int RandomPhases = 6;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               func_i;
  logic [15:0]        trigger_word_i;
  logic [15:0]        vernier_word_i;
  logic [1:0]         channel_i;
  logic [11:0]        cell_req_i;
  logic [15:0]        sample_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               kind_o;
  logic signed [12:0] rotation_o;
  logic [11:0]        aligned_cell_o;
  logic [1:0]         out_channel_o;
  logic signed [12:0] corrected_o;
  logic [11:0]        peak_value_o;
  logic [1:0]         peak_channel_o;
  logic [11:0]        peak_cell_o;

  int fail_count;
  int pending;
  int cycle_count  = 0;
  int header_count = 0;
  int sample_count = 0;
  int learn_writes = 0;
  bit quiet        = 1'b0;

  waveform_pedestal_align_peak u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .trigger_word_i (trigger_word_i),
    .vernier_word_i (vernier_word_i),
    .channel_i      (channel_i),
    .cell_req_i     (cell_req_i),
    .sample_word_i  (sample_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .rotation_o     (rotation_o),
    .aligned_cell_o (aligned_cell_o),
    .out_channel_o  (out_channel_o),
    .corrected_o    (corrected_o),
    .peak_value_o   (peak_value_o),
    .peak_channel_o (peak_channel_o),
    .peak_cell_o    (peak_cell_o)
  );

  pedestal_peak_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .func_i         (func_i),
    .trigger_word_i (trigger_word_i),
    .vernier_word_i (vernier_word_i),
    .channel_i      (channel_i),
    .cell_req_i     (cell_req_i),
    .sample_word_i  (sample_word_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_i         (kind_o),
    .rotation_i     (rotation_o),
    .aligned_cell_i (aligned_cell_o),
    .out_channel_i  (out_channel_o),
    .corrected_i    (corrected_o),
    .peak_value_i   (peak_value_o),
    .peak_channel_i (peak_channel_o),
    .peak_cell_i    (peak_cell_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case results stop coming
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("waveform_pedestal_align_peak_test: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure in bursts, off for the final phase
  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 3) != 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  // Drive one beat; valid stays high afterwards unless a gap or a pause follows
  task automatic send_item(func_e fn, logic [15:0] trig, logic [15:0] vern,
                           logic [1:0] ch, logic [11:0] cell_sel, logic [15:0] word);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    trigger_word_i <= trig;
    vernier_word_i <= vern;
    channel_i      <= ch;
    cell_req_i     <= cell_sel;
    sample_word_i  <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (fn == FuncHeader) header_count++;
    else sample_count++;
  endtask

  // Learn mode changes only with the pipe drained
  task automatic set_learn(logic v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    learn_writes++;
  endtask

  // Events: a header then 0..40 samples, mostly on a few hot cells so
  // pedestal sums build up, wrap, and push corrections negative
  task automatic run_random_phase(int n_items);
    int          left, burst, pick;
    logic [11:0] cell_sel;
    logic [15:0] word, trig, vern;
    left  = n_items;
    burst = 0;
    while (left > 0) begin
      if (burst == 0) begin
        trig = rand16();
        vern = rand16();
        pick = $urandom_range(0, 9);
        case (pick)
          0: trig[7:0] = 8'h00;
          1: trig[7:0] = 8'hff;
          2: vern = 16'h0000;
          3: vern = 16'hffff;
          default: ;
        endcase
        send_item(FuncHeader, trig, vern, 2'($urandom), 12'($urandom), rand16());
        burst = $urandom_range(0, 40);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          case ($urandom_range(0, 7))
            0: cell_sel = 12'd0;
            1: cell_sel = 12'd1;
            2: cell_sel = 12'd2559;
            3: cell_sel = 12'd2560;
            4: cell_sel = 12'd4095;
            5: cell_sel = 12'd1234;
            6: cell_sel = 12'd700;
            default: cell_sel = 12'd2000;
          endcase
        end else begin
          cell_sel = 12'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) word = rand16();
        else if (pick < 7) word = {4'($urandom), 12'($urandom_range(0, 300))};
        else word = {4'($urandom), 12'($urandom_range(3800, 4095))};
        send_item(FuncSample, rand16(), rand16(), 2'($urandom), cell_sel, word);
        burst--;
      end
      left--;
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= 1'b0;
    in_valid_i     <= 1'b0;
    func_i         <= FuncHeader;
    trigger_word_i <= '0;
    vernier_word_i <= '0;
    channel_i      <= '0;
    cell_req_i     <= '0;
    sample_word_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: learn off, pedestals zero, so corrected equals the raw sample
    send_item(FuncSample, rand16(), rand16(), 2'd0, 12'd5, 16'hf123);     // before any header
    send_item(FuncHeader, 16'hff00, 16'h0000, 2'd0, 12'd0, 16'h0000);    // largest rotation
    send_item(FuncSample, rand16(), rand16(), 2'd3, 12'd4095, 16'hffff); // cell wraps, max raw
    send_item(FuncSample, rand16(), rand16(), 2'd1, 12'd2559, 16'h0fff); // tie keeps peak
    send_item(FuncSample, rand16(), rand16(), 2'd2, 12'd2560, 16'h1000); // raw zero
    send_item(FuncHeader, 16'h00ff, 16'hffff, 2'd3, 12'd4095, 16'hffff); // most negative
    send_item(FuncSample, rand16(), rand16(), 2'd0, 12'd0, 16'h0001);
    send_item(FuncHeader, 16'h0080, 16'd6700, 2'd0, 12'd0, 16'h0000);    // zero rotation
    send_item(FuncSample, rand16(), rand16(), 2'd1, 12'd2559, 16'h8000);

    // Directed: learn on, pile one address up to the top of the sum range,
    // then saturate the correction negative and wrap the sum
    set_learn(1'b1);
    send_item(FuncHeader, 16'h0040, 16'h1234, 2'd0, 12'd0, 16'h0000);
    for (int i = 0; i < 16; i++) begin
      send_item(FuncSample, rand16(), rand16(), 2'd2, 12'd100, 16'h0fff);
    end
    send_item(FuncSample, rand16(), rand16(), 2'd2, 12'd100, 16'hf000);
    send_item(FuncSample, rand16(), rand16(), 2'd2, 12'd100, 16'h0fff);
    send_item(FuncSample, rand16(), rand16(), 2'd2, 12'd100, 16'h0000);

    // Random: learn mode alternates, last phase runs without idling
    for (int p = 0; p < RandomPhases; p++) begin
      set_learn(p % 2 == 1);
      quiet = (p == RandomPhases - 1);
      run_random_phase(PhaseItems);
    end

    // Drain
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d headers and %0d samples across %0d learn-mode writes,",
             header_count, sample_count, learn_writes);
    $display("with hot cells driving pedestal sums through wrap and negative saturation.");
    if (fail_count == 0) begin
      $display("waveform_pedestal_align_peak_test: PASS");
    end else begin
      $display("waveform_pedestal_align_peak_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== waveform_pedestal_align_peak.f =====
hw/rtl/wpap_pkg.sv
hw/rtl/wpap_ram.sv
hw/rtl/wpap_rot.sv
hw/rtl/wpap_fifo.sv
hw/rtl/waveform_pedestal_align_peak.sv
tb/pedestal_peak_checker.sv
tb/waveform_pedestal_align_peak_test.sv
